// ===== rtl/core/apt_pkg.sv =====
// ----------------------------------------------------------------------------
// apt_pkg
// types and codes shared by the pending ack tracker files
// ----------------------------------------------------------------------------
`default_nettype none

package apt_pkg;

  // command codes
  localparam logic [2:0] CMD_NEW_ID    = 3'd0;
  localparam logic [2:0] CMD_ACK       = 3'd1;
  localparam logic [2:0] CMD_SET_NOTIFY = 3'd2;
  localparam logic [2:0] CMD_NACK_ONE  = 3'd3;
  localparam logic [2:0] CMD_NACK_ALL  = 3'd4;
  localparam logic [2:0] CMD_SWEEP     = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_NO_ID      = 3'd3;
  localparam logic [2:0] ST_ZERO_ID    = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_STATUS   = 2'd0;
  localparam logic [1:0] KIND_ACKED    = 2'd1;
  localparam logic [1:0] KIND_FAILED   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ACK_LIMIT  = 2'd0;
  localparam logic [1:0] REG_ACK_TYPE   = 2'd1;
  localparam logic [1:0] REG_UNAVAIL_TYPE = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // reset values of the registers
  localparam logic [15:0] ACK_LIMIT_RST    = 16'd30;
  localparam logic [7:0]  ACK_TYPE_RST     = 8'd0;
  localparam logic [7:0]  UNAVAIL_TYPE_RST = 8'd1;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  msg_type;
    logic [31:0] packet_id;
    logic [31:0] user_tag;
    logic [31:0] now_seconds;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  status;
    logic [31:0] out_packet_id;
    logic [31:0] out_tag;
    logic        last;
  } res_t;

  // one table entry as held in memory
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] created;
    logic [31:0] tag;
  } entry_t;

  localparam int unsigned EntryW = 96;

endpackage

`default_nettype wire

// ===== rtl/core/apt_ram.sv =====
// ----------------------------------------------------------------------------
// apt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module apt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/ack_pending_tracker.sv =====
// ----------------------------------------------------------------------------
// ack_pending_tracker
// table of outstanding packet ids with notify tags, ack, nack and age sweep
// ----------------------------------------------------------------------------
// type check, full table, zero id and unknown commands answer the cycle after
//   start; others answer after a full table scan, ack and nack one with notify
//   give a notification first, then the status in the next cycle
// nack all and sweep repeat the scan once per removed entry; one item at a time;
//   the single read port of the entry memory, one entry a cycle, paces the scan
// reset clears valid, notify bits, id counter, presets config; results never stall
`default_nettype none

module ack_pending_tracker #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command side
  input  wire logic                          start,
  output logic                               busy,
  input  wire apt_pkg::cmd_t                 cmd_i,
  // result side
  output logic                               strobe,
  output apt_pkg::res_t                      res_o,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [apt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [apt_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] CntLast = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_STAT
  } state_e;

  // configuration registers
  logic [15:0] limit_q;
  logic [7:0]  ack_type_q;
  logic [7:0]  unavail_type_q;

  // control state
  state_e state_q, state_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [TABLE_DEPTH-1:0] notify_q, notify_d;
  logic [31:0] last_id_q, last_id_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic found_q, found_d;
  logic strobe_q, strobe_d;

  // captured command and scan results
  apt_pkg::cmd_t cmd_q, cmd_d;
  logic [31:0] key_q, key_d;
  logic [AW-1:0] free_q, free_d;
  logic [AW-1:0] best_idx_q, best_idx_d;
  apt_pkg::entry_t best_q, best_d;
  apt_pkg::res_t res_q, res_d;

  // entry memory ports
  logic ram_we;
  logic [AW-1:0] ram_waddr;
  apt_pkg::entry_t ram_wdata;
  logic ram_re;
  apt_pkg::entry_t ram_rdata;

  // free slot search over the valid bits
  logic free_any;
  logic [AW-1:0] free_idx;

  // scan evaluation of the entry that just came out of memory
  logic [AW-1:0] eidx;
  logic [31:0] age;
  logic expired;
  logic take;
  logic [31:0] next_id;
  logic accept;

  apt_ram #(
    .Width (apt_pkg::EntryW),
    .Depth (TABLE_DEPTH),
    .AddrW (AW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign accept = start && !busy;

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!valid_q[i] && !free_any) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  // id counter wraps and skips zero
  assign next_id = (last_id_q == 32'hFFFF_FFFF) ? 32'd1 : last_id_q + 32'd1;

  // read data belongs to the address issued in the previous cycle
  assign eidx    = AW'(cnt_q - CW'(1));
  assign age     = cmd_q.now_seconds - ram_rdata.created;
  assign expired = !age[31] && (age > {16'd0, limit_q});

  always_comb begin
    take = 1'b0;
    if (cmd_q.command == apt_pkg::CMD_NACK_ALL || cmd_q.command == apt_pkg::CMD_SWEEP) begin
      // minimum id among eligible entries
      take = valid_q[eidx]
          && (cmd_q.command != apt_pkg::CMD_SWEEP || expired)
          && (!found_q || ram_rdata.id < best_q.id);
    end else begin
      // first entry whose id matches the key
      take = valid_q[eidx] && (ram_rdata.id == key_q) && !found_q;
    end
  end

  assign ram_re = (state_q == S_SCAN) && (cnt_q < CntLast);

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    notify_d   = notify_q;
    last_id_d  = last_id_q;
    cnt_d      = cnt_q;
    found_d    = found_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    free_d     = free_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    strobe_d   = 1'b0;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = free_q;
    ram_wdata  = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_i;
          key_d   = cmd_i.packet_id;
          cnt_d   = '0;
          found_d = 1'b0;
          res_d   = '{result_kind: apt_pkg::KIND_STATUS, status: apt_pkg::ST_OK,
                      out_packet_id: 32'd0, out_tag: 32'd0, last: 1'b1};
          case (cmd_i.command)
            apt_pkg::CMD_NEW_ID: begin
              if (cmd_i.msg_type == ack_type_q || cmd_i.msg_type == unavail_type_q) begin
                strobe_d     = 1'b1;
                res_d.status = apt_pkg::ST_NO_ID;
              end else if (!free_any) begin
                strobe_d     = 1'b1;
                res_d.status = apt_pkg::ST_FULL;
              end else begin
                // check the new id against pending ones before placing it
                last_id_d = next_id;
                key_d     = next_id;
                free_d    = free_idx;
                state_d   = S_SCAN;
              end
            end
            apt_pkg::CMD_ACK, apt_pkg::CMD_NACK_ONE,
            apt_pkg::CMD_NACK_ALL, apt_pkg::CMD_SWEEP: begin
              state_d = S_SCAN;
            end
            apt_pkg::CMD_SET_NOTIFY: begin
              if (cmd_i.packet_id == 32'd0) begin
                strobe_d     = 1'b1;
                res_d.status = apt_pkg::ST_ZERO_ID;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              strobe_d = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q != '0 && take) begin
          found_d    = 1'b1;
          best_idx_d = eidx;
          best_d     = ram_rdata;
        end
        if (cnt_q == CntLast) begin
          state_d = S_ACT;
        end
      end

      S_ACT: begin
        res_d = '{result_kind: apt_pkg::KIND_STATUS, status: apt_pkg::ST_OK,
                  out_packet_id: 32'd0, out_tag: 32'd0, last: 1'b1};
        strobe_d = 1'b1;
        state_d  = S_IDLE;
        case (cmd_q.command)
          apt_pkg::CMD_NEW_ID: begin
            // duplicate id keeps the old entry
            if (!found_q) begin
              ram_we    = 1'b1;
              ram_waddr = free_q;
              ram_wdata = '{id: key_q, created: cmd_q.now_seconds, tag: 32'd0};
              valid_d[free_q]  = 1'b1;
              notify_d[free_q] = 1'b0;
            end
            res_d.out_packet_id = key_q;
          end
          apt_pkg::CMD_SET_NOTIFY: begin
            if (found_q) begin
              ram_we    = 1'b1;
              ram_waddr = best_idx_q;
              ram_wdata = '{id: best_q.id, created: best_q.created,
                            tag: cmd_q.user_tag};
              notify_d[best_idx_q] = 1'b1;
            end else begin
              res_d.status = apt_pkg::ST_NOT_FOUND;
            end
          end
          apt_pkg::CMD_ACK, apt_pkg::CMD_NACK_ONE: begin
            if (!found_q) begin
              res_d.status = apt_pkg::ST_NOT_FOUND;
            end else begin
              valid_d[best_idx_q]  = 1'b0;
              notify_d[best_idx_q] = 1'b0;
              if (notify_q[best_idx_q]) begin
                res_d = '{result_kind: (cmd_q.command == apt_pkg::CMD_ACK) ?
                                       apt_pkg::KIND_ACKED : apt_pkg::KIND_FAILED,
                          status: apt_pkg::ST_OK, out_packet_id: best_q.id,
                          out_tag: best_q.tag, last: 1'b0};
                state_d = S_STAT;
              end
            end
          end
          apt_pkg::CMD_NACK_ALL, apt_pkg::CMD_SWEEP: begin
            if (found_q) begin
              // drop the lowest id and go for another pass
              valid_d[best_idx_q]  = 1'b0;
              notify_d[best_idx_q] = 1'b0;
              strobe_d = notify_q[best_idx_q];
              res_d = '{result_kind: apt_pkg::KIND_FAILED, status: apt_pkg::ST_OK,
                        out_packet_id: best_q.id, out_tag: best_q.tag, last: 1'b0};
              cnt_d   = '0;
              found_d = 1'b0;
              state_d = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end

      S_STAT: begin
        strobe_d = 1'b1;
        res_d    = '{result_kind: apt_pkg::KIND_STATUS, status: apt_pkg::ST_OK,
                     out_packet_id: 32'd0, out_tag: 32'd0, last: 1'b1};
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      valid_q        <= '0;
      notify_q       <= '0;
      last_id_q      <= '0;
      cnt_q          <= '0;
      found_q        <= 1'b0;
      strobe_q       <= 1'b0;
      limit_q        <= apt_pkg::ACK_LIMIT_RST;
      ack_type_q     <= apt_pkg::ACK_TYPE_RST;
      unavail_type_q <= apt_pkg::UNAVAIL_TYPE_RST;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      notify_q  <= notify_d;
      last_id_q <= last_id_d;
      cnt_q     <= cnt_d;
      found_q   <= found_d;
      strobe_q  <= strobe_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          apt_pkg::REG_ACK_LIMIT:    limit_q        <= cfg_data_i;
          apt_pkg::REG_ACK_TYPE:     ack_type_q     <= cfg_data_i[7:0];
          apt_pkg::REG_UNAVAIL_TYPE: unavail_type_q <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    free_q     <= free_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    res_q      <= res_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign strobe = strobe_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/apt_checker.sv =====
// ----------------------------------------------------------------------------
// apt_checker
// port level checks of the pending ack tracker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module apt_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          strobe,
  input wire apt_pkg::res_t res_o
);

  // a command ends only with its final status item
  a_end_with_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> strobe && res_o.last)
    else $error("busy dropped without a final status item");

  // notifications appear only while a command is running
  a_notify_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && !res_o.last |-> busy)
    else $error("notification item outside a command");

  // an accepted command either runs or answers at once
  a_accept_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || (strobe && res_o.last))
    else $error("accepted command neither runs nor answers");

  // final item is a status, other items are notifications with status ok
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> (res_o.last && res_o.result_kind == apt_pkg::KIND_STATUS) ||
               (!res_o.last && res_o.status == apt_pkg::ST_OK &&
                (res_o.result_kind == apt_pkg::KIND_ACKED ||
                 res_o.result_kind == apt_pkg::KIND_FAILED)))
    else $error("result kind does not fit last flag");

endmodule

bind ack_pending_tracker apt_checker u_apt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .res_o  (res_o)
);

`default_nettype wire
